### rtl/core/kslrl_pkg.sv
// ----------------------------------------------------------------------------
// kslrl_pkg
// Shared widths, operation codes, register indexes and the command/status
// structs between the limiter controller and datapath.
// ----------------------------------------------------------------------------
package kslrl_pkg;

   localparam int KEY_W       = 64;
   localparam int NOW_W       = 48;
   localparam int WIN_W       = 32;
   localparam int LIM_W       = 5;
   localparam int FUNC_W      = 3;
   localparam int REQ_DATA_W  = 176;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // request field offsets inside req_tdata
   localparam int KEY_HIGH_LSB = 0;
   localparam int KEY_LOW_LSB  = 64;
   localparam int NOW_LSB      = 128;

   // result bit positions inside rsp_tdata
   localparam int RSP_LIMITED = 0;
   localparam int RSP_FOUND   = 1;
   localparam int RSP_DROPPED = 2;

   localparam logic [FUNC_W-1:0] FUNC_REC_REG   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REC_LOGIN = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_QRY_REG   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_QRY_LOGIN = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QRY_SUSP  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REG_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOGIN_LIMIT = 2'd2;

   localparam logic [WIN_W-1:0] WINDOW_RESET      = 32'd3600000;
   localparam logic [LIM_W-1:0] REG_LIMIT_RESET   = 5'd5;
   localparam logic [LIM_W-1:0] LOGIN_LIMIT_RESET = 5'd10;

   typedef struct packed {
      logic load;        // latch the request, restart the key walk
      logic search;      // advance the key walk
      logic meta_rd;     // read the slot's log pointers
      logic meta_load;   // take pointers into working registers
      logic push;        // append the stamp, claim slot if new
      logic prune_init;  // set up a pruning pass
      logic prune_run;   // advance the pruning pass
      logic prune_sel;   // 0 registration log, 1 login log
      logic finish;      // form result, write back, clear slot
      logic emit;        // load the output register
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              search_done;
      logic              hit;
      logic              free;
      logic              prune_done;
      logic              rsp_free;
   } sts_type;

endpackage

### rtl/core/keyed_sliding_log_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// keyed_sliding_log_rate_limiter_core
// Per-key sliding window log limiter for registration and login attempts.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | tuser func, tdata key and time
//   rsp     | out       | rsp_tvalid/tready    | tdata limited, found, dropped
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One item at a time. The key walk visits up to ENTRIES slots, one key
// memory read per cycle; a query then prunes each log it reads through
// the stamp memory port; pointer fetch, write-back and hand-off complete
// the item. Reset is synchronous and clears the slot valid bits, loads the
// configuration defaults and idles the controller; stamps and pointers are
// set when a slot is claimed. A stalled result holds in the output register;
// the next item is taken meanwhile and waits only at hand-off.
// ----------------------------------------------------------------------------
module keyed_sliding_log_rate_limiter_core #(
   parameter int ENTRIES   = 64,
   parameter int LOG_DEPTH = 16,
   parameter int TIME_BITS = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] key_high, [127:64] key_low, [175:128] now_ms
   input  logic [kslrl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] func
   input  logic [kslrl_pkg::FUNC_W-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] limited, [1] found, [2] dropped, [7:3] zero
   output logic [kslrl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kslrl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kslrl_pkg::CSR_DATA_W-1:0]  csr_data
);
   import kslrl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   kslrl_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kslrl_datapath #(
      .ENTRIES   (ENTRIES),
      .LOG_DEPTH (LOG_DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

### rtl/core/kslrl_datapath.sv
// ----------------------------------------------------------------------------
// kslrl_datapath
// Key table, log memories, pruning walk, configuration and result register.
// ----------------------------------------------------------------------------
module kslrl_datapath #(
   parameter int ENTRIES   = 64,
   parameter int LOG_DEPTH = 16,
   parameter int TIME_BITS = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [kslrl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kslrl_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [kslrl_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [kslrl_pkg::FUNC_W-1:0]          req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [kslrl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  kslrl_pkg::cmd_type                    cmd,
   output kslrl_pkg::sts_type                    sts
);
   import kslrl_pkg::*;

   localparam int AW       = $clog2(ENTRIES);
   localparam int PW       = $clog2(LOG_DEPTH);
   localparam int CW       = $clog2(LOG_DEPTH + 1);
   localparam int XW       = CW + 1;
   localparam int SW       = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
   localparam int LA       = AW + PW;
   localparam int LOG_ROWS = ENTRIES * (1 << PW);
   localparam int MW       = 2 * (PW + CW);
   localparam int SUMW     = ((CW > LIM_W) ? CW : LIM_W) + 1;
   localparam logic [AW:0]   LAST_IDX = (AW + 1)'(ENTRIES);
   localparam logic [PW-1:0] TOP_P    = PW'(LOG_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(LOG_DEPTH);

   // configuration
   logic [WIN_W-1:0] window_ff;
   logic [LIM_W-1:0] reg_lim_ff, log_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         reg_lim_ff <= REG_LIMIT_RESET;
         log_lim_ff <= LOGIN_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW:      window_ff  <= csr_data;
            CSR_REG_LIMIT:   reg_lim_ff <= csr_data[LIM_W-1:0];
            CSR_LOGIN_LIMIT: log_lim_ff <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // request
   logic [FUNC_W-1:0]  func_ff;
   logic [2*KEY_W-1:0] key_ff;
   logic [SW-1:0]      now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser;
         key_ff  <= {req_tdata[KEY_HIGH_LSB +: KEY_W], req_tdata[KEY_LOW_LSB +: KEY_W]};
         now_ff  <= req_tdata[NOW_LSB +: SW];
      end
   end

   // key walk
   logic [AW:0]        idx_ff;
   logic               cmp_vld_ff, hit_ff, free_ff;
   logic [AW-1:0]      cmp_idx_ff, hit_idx_ff, free_idx_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [2*KEY_W-1:0] key_mem [ENTRIES];
   logic [2*KEY_W-1:0] key_rd_ff;
   logic               claim;
   logic [AW-1:0]      slot;

   assign claim = !hit_ff && free_ff;
   assign slot  = hit_ff ? hit_idx_ff : free_idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.push && claim) begin
         key_mem[free_idx_ff] <= key_ff;
      end
      key_rd_ff <= key_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
      end else if (cmd.load) begin
         idx_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
      end else if (cmd.search) begin
         if (idx_ff != LAST_IDX && !hit_ff) begin
            idx_ff     <= idx_ff + 1'b1;
            cmp_vld_ff <= 1'b1;
            cmp_idx_ff <= idx_ff[AW-1:0];
         end else begin
            cmp_vld_ff <= 1'b0;
         end
         if (cmp_vld_ff && !hit_ff) begin
            if (valid_ff[cmp_idx_ff] && key_rd_ff == key_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= cmp_idx_ff;
            end
            if (!valid_ff[cmp_idx_ff] && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= cmp_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.push && claim) begin
         valid_ff[free_idx_ff] <= 1'b1;
      end else if (cmd.finish && func_ff == FUNC_CLEAR && hit_ff) begin
         valid_ff[hit_idx_ff] <= 1'b0;
      end
   end

   // log pointers per slot: {reg head, reg count, login head, login count}
   logic [MW-1:0] meta_mem [ENTRIES];
   logic [MW-1:0] meta_rd_ff, meta_wdata;
   logic          meta_we;
   logic [PW-1:0] rh_ff, lh_ff, head_sel, head_nx;
   logic [CW-1:0] rc_ff, lc_ff, cnt_sel, cnt_nx;
   logic          push_login, is_query;

   assign push_login = (func_ff == FUNC_REC_LOGIN);
   assign head_sel   = push_login ? lh_ff : rh_ff;
   assign cnt_sel    = push_login ? lc_ff : rc_ff;
   assign head_nx    = (head_sel == TOP_P) ? '0 : head_sel + 1'b1;
   assign cnt_nx     = (cnt_sel == DEPTH_C) ? cnt_sel : cnt_sel + 1'b1;
   assign is_query   = (func_ff == FUNC_QRY_REG) || (func_ff == FUNC_QRY_LOGIN)
                       || (func_ff == FUNC_QRY_SUSP);

   always_comb begin
      meta_we    = 1'b0;
      meta_wdata = {rh_ff, rc_ff, lh_ff, lc_ff};
      if (cmd.push) begin
         meta_we    = 1'b1;
         meta_wdata = push_login ? {rh_ff, rc_ff, head_nx, cnt_nx}
                                 : {head_nx, cnt_nx, lh_ff, lc_ff};
      end else if (cmd.finish && is_query && hit_ff) begin
         meta_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[slot] <= meta_wdata;
      end
      if (cmd.meta_rd) begin
         meta_rd_ff <= meta_mem[slot];
      end
   end

   // pruning walk
   logic [CW-1:0] n_ff, i_ff, kept_ff, n_init;
   logic [PW-1:0] rd_ptr_ff, wr_ptr_ff, h_init;
   logic [XW-1:0] start_x;
   logic          pend_ff, prune_done, keep;
   logic [SW-1:0] stamp, win_ext, reg_rd_ff, lgn_rd_ff;
   logic [SW-1:0] reg_log [LOG_ROWS];
   logic [SW-1:0] lgn_log [LOG_ROWS];
   logic [LA-1:0] rd_addr, wr_addr;
   logic [SW-1:0] log_wdata;
   logic          reg_we, lgn_we;

   assign n_init  = cmd.prune_sel ? lc_ff : rc_ff;
   assign h_init  = cmd.prune_sel ? lh_ff : rh_ff;
   assign start_x = (XW'(h_init) >= XW'(n_init)) ? XW'(h_init) - XW'(n_init)
                    : XW'(h_init) + XW'(LOG_DEPTH) - XW'(n_init);
   assign stamp   = cmd.prune_sel ? lgn_rd_ff : reg_rd_ff;
   assign win_ext = SW'(window_ff);
   assign keep    = (now_ff < win_ext) || (stamp >= now_ff - win_ext);
   assign prune_done = (i_ff == n_ff) && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.prune_init) begin
         n_ff      <= n_init;
         i_ff      <= '0;
         kept_ff   <= '0;
         rd_ptr_ff <= start_x[PW-1:0];
         wr_ptr_ff <= start_x[PW-1:0];
         pend_ff   <= 1'b0;
      end else if (cmd.prune_run) begin
         if (i_ff != n_ff) begin
            i_ff      <= i_ff + 1'b1;
            rd_ptr_ff <= (rd_ptr_ff == TOP_P) ? '0 : rd_ptr_ff + 1'b1;
            pend_ff   <= 1'b1;
         end else begin
            pend_ff <= 1'b0;
         end
         if (pend_ff && keep) begin
            wr_ptr_ff <= (wr_ptr_ff == TOP_P) ? '0 : wr_ptr_ff + 1'b1;
            kept_ff   <= kept_ff + 1'b1;
         end
      end
   end

   // working pointers
   always_ff @(posedge clock) begin
      if (cmd.meta_load) begin
         if (claim) begin
            {rh_ff, rc_ff, lh_ff, lc_ff} <= '0;
         end else begin
            {rh_ff, rc_ff, lh_ff, lc_ff} <= meta_rd_ff;
         end
      end else if (cmd.prune_run && prune_done) begin
         if (cmd.prune_sel) begin
            lh_ff <= wr_ptr_ff;
            lc_ff <= kept_ff;
         end else begin
            rh_ff <= wr_ptr_ff;
            rc_ff <= kept_ff;
         end
      end
   end

   // stamp memories: one write and one read each per cycle
   always_comb begin
      rd_addr   = {slot, rd_ptr_ff};
      reg_we    = 1'b0;
      lgn_we    = 1'b0;
      wr_addr   = {slot, wr_ptr_ff};
      log_wdata = stamp;
      if (cmd.push) begin
         wr_addr   = {slot, head_sel};
         log_wdata = now_ff;
         reg_we    = !push_login;
         lgn_we    = push_login;
      end else if (cmd.prune_run && pend_ff && keep) begin
         reg_we = !cmd.prune_sel;
         lgn_we = cmd.prune_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reg_we) begin
         reg_log[wr_addr] <= log_wdata;
      end
      reg_rd_ff <= reg_log[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lgn_we) begin
         lgn_log[wr_addr] <= log_wdata;
      end
      lgn_rd_ff <= lgn_log[rd_addr];
   end

   // result
   logic [SUMW-1:0] cnt_sum, lim_sum;
   logic            limited, found, dropped;
   logic [2:0]      res_ff;
   logic [2:0]      out_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   assign cnt_sum = SUMW'(rc_ff) + SUMW'(lc_ff);
   assign lim_sum = SUMW'(reg_lim_ff) + SUMW'(log_lim_ff);

   always_comb begin
      case (func_ff)
         FUNC_QRY_REG:   limited = hit_ff && (SUMW'(rc_ff) >= SUMW'(reg_lim_ff));
         FUNC_QRY_LOGIN: limited = hit_ff && (SUMW'(lc_ff) >= SUMW'(log_lim_ff));
         FUNC_QRY_SUSP:  limited = hit_ff && (cnt_sum > lim_sum);
         default:        limited = 1'b0;
      endcase
   end

   assign found   = hit_ff && (func_ff <= FUNC_CLEAR);
   assign dropped = (func_ff <= FUNC_REC_LOGIN) && !hit_ff && !free_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_ff <= {dropped, found, limited};
      end
      if (cmd.emit) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 3)'(0), out_ff[RSP_DROPPED], out_ff[RSP_FOUND],
                        out_ff[RSP_LIMITED]};

   assign sts.func        = func_ff;
   assign sts.search_done = hit_ff || (idx_ff == LAST_IDX && !cmp_vld_ff);
   assign sts.hit         = hit_ff;
   assign sts.free        = free_ff;
   assign sts.prune_done  = prune_done;
   assign sts.rsp_free    = !rsp_valid_ff || rsp_tready;

endmodule

### rtl/core/kslrl_controller.sv
// ----------------------------------------------------------------------------
// kslrl_controller
// Sequencer for one operation: key walk, pointer fetch, append or prune,
// write-back and result hand-off.
// ----------------------------------------------------------------------------
module kslrl_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  kslrl_pkg::sts_type sts,
   output kslrl_pkg::cmd_type cmd
);
   import kslrl_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b00000000001,
      ST_SEARCH    = 11'b00000000010,
      ST_META_RD   = 11'b00000000100,
      ST_META_WAIT = 11'b00000001000,
      ST_PUSH      = 11'b00000010000,
      ST_PREP_REG  = 11'b00000100000,
      ST_PRUNE_REG = 11'b00001000000,
      ST_PREP_LGN  = 11'b00010000000,
      ST_PRUNE_LGN = 11'b00100000000,
      ST_FINISH    = 11'b01000000000,
      ST_DONE      = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      is_record, is_query;

   assign is_record = (sts.func == FUNC_REC_REG) || (sts.func == FUNC_REC_LOGIN);
   assign is_query  = (sts.func == FUNC_QRY_REG) || (sts.func == FUNC_QRY_LOGIN)
                      || (sts.func == FUNC_QRY_SUSP);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (sts.search_done) begin
               if ((is_record && (sts.hit || sts.free)) || (is_query && sts.hit)) begin
                  state_in = ST_META_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_META_RD: begin
            cmd.meta_rd = 1'b1;
            state_in    = ST_META_WAIT;
         end
         ST_META_WAIT: begin
            cmd.meta_load = 1'b1;
            if (is_record) begin
               state_in = ST_PUSH;
            end else if (sts.func == FUNC_QRY_LOGIN) begin
               state_in = ST_PREP_LGN;
            end else begin
               state_in = ST_PREP_REG;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_FINISH;
         end
         ST_PREP_REG: begin
            cmd.prune_init = 1'b1;
            state_in       = ST_PRUNE_REG;
         end
         ST_PRUNE_REG: begin
            cmd.prune_run = 1'b1;
            if (sts.prune_done) begin
               state_in = (sts.func == FUNC_QRY_SUSP) ? ST_PREP_LGN : ST_FINISH;
            end
         end
         ST_PREP_LGN: begin
            cmd.prune_init = 1'b1;
            cmd.prune_sel  = 1'b1;
            state_in       = ST_PRUNE_LGN;
         end
         ST_PRUNE_LGN: begin
            cmd.prune_run = 1'b1;
            cmd.prune_sel = 1'b1;
            if (sts.prune_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/kslrl_checker.sv
// ----------------------------------------------------------------------------
// kslrl_checker
// Port-level checks on the limiter core, bound to the top level.
// ----------------------------------------------------------------------------
module kslrl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [kslrl_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import kslrl_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a dropped record never reports a present key
   a_drop_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_DROPPED] && rsp_tdata[RSP_FOUND]))
      else $error("dropped and found together");

   // only a present key can be limited
   a_limited_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_LIMITED] |-> rsp_tdata[RSP_FOUND])
      else $error("limited without found");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // a new result appears only after the block was busy
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without work");

endmodule

bind keyed_sliding_log_rate_limiter_core kslrl_checker u_kslrl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
